/* src/cgrp_pkg.sv */
package cgrp_pkg;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_RECORD = 2'd1,
      PHASE_IDLE   = 2'd2
   } phase_type;

   localparam logic [3:0]  HEADER_BYTES = 4'd10;
   localparam logic [15:0] F_WORDS      = 16'h0001;
   localparam logic [15:0] F_UNIFORM    = 16'h0008;
   localparam logic [15:0] F_MORE       = 16'h0020;
   localparam logic [15:0] F_XY         = 16'h0040;
   localparam logic [15:0] F_MATRIX     = 16'h0080;
   localparam logic [15:0] ONE_F2DOT14  = 16'd16384;

   localparam logic [1:0] KIND_UNIFORM = 2'd0;
   localparam logic [1:0] KIND_XY      = 2'd1;
   localparam logic [1:0] KIND_MATRIX  = 2'd2;

   typedef struct packed {
      logic [15:0] glyph_number;
      logic [15:0] component_glyph;
      logic [15:0] component_flags;
      logic [15:0] first_argument;
      logic [15:0] second_argument;
      logic [1:0]  transform_kind;
      logic [15:0] transform_a;
      logic [15:0] transform_b;
      logic [15:0] transform_c;
      logic [15:0] transform_d;
      logic        last_component;
   } result_type;

   // even offset loads the high byte, odd the low byte
   function automatic logic [15:0] put_byte(input logic [15:0] w, input logic odd,
                                            input logic [7:0] b);
      logic [15:0] r;
      if (!odd) begin
         r = {b, w[7:0]};
      end else begin
         r = {w[15:8], b};
      end
      return r;
   endfunction

endpackage

/* src/cgrp_parser.sv */
module cgrp_parser
   import cgrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] data_byte,
   input  logic       glyph_end,
   output logic       emit,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [15:0] counter_ff, counter_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] index_ff, index_in;
   logic [15:0] arg_ff [2];
   logic [15:0] arg_in [2];
   logic [15:0] xf_ff [4];
   logic [15:0] xf_in [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_HEADER;
         pos_ff     <= '0;
         counter_ff <= '0;
         high_ff    <= '0;
      end else if (byte_valid) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         counter_ff <= counter_in;
         high_ff    <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_valid) begin
         flags_ff <= flags_in;
         index_ff <= index_in;
         arg_ff   <= arg_in;
         xf_ff    <= xf_in;
      end
   end

   logic [3:0] off;
   logic [3:0] toff;
   logic [4:0] total;
   logic [4:0] next_pos;
   logic [4:0] tlen;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      counter_in = counter_ff;
      high_in    = high_ff;
      flags_in   = flags_ff;
      index_in   = index_ff;
      arg_in     = arg_ff;
      xf_in      = xf_ff;
      emit       = 1'b0;
      off        = pos_ff - 4'd4;
      toff       = '0;
      tlen       = '0;
      total      = '0;
      next_pos   = {1'b0, pos_ff} + 5'd1;

      unique case (phase_ff)
         PHASE_HEADER: begin
            if (pos_ff == 4'd0) begin
               high_in = data_byte;
            end
            if (next_pos >= {1'b0, HEADER_BYTES}) begin
               phase_in = high_ff[7] ? PHASE_RECORD : PHASE_IDLE;
               pos_in   = '0;
            end else begin
               pos_in = next_pos[3:0];
            end
         end
         PHASE_RECORD: begin
            if (pos_ff == 4'd0) begin
               flags_in  = '0;
               index_in  = '0;
               arg_in[0] = '0;
               arg_in[1] = '0;
               xf_in[0]  = '0;
               xf_in[1]  = '0;
               xf_in[2]  = '0;
               xf_in[3]  = '0;
            end
            if (pos_ff < 4'd2) begin
               flags_in = put_byte(flags_in, pos_ff[0], data_byte);
            end else if (pos_ff < 4'd4) begin
               index_in = put_byte(index_in, pos_ff[0], data_byte);
            end else if ((flags_in & F_WORDS) != '0) begin
               if (off < 4'd4) begin
                  arg_in[off[1]] = put_byte(arg_in[off[1]], off[0], data_byte);
               end else begin
                  toff = off - 4'd4;
                  xf_in[toff[2:1]] = put_byte(xf_in[toff[2:1]], toff[0], data_byte);
               end
            end else begin
               if (off < 4'd2) begin
                  arg_in[off[0]] = {8'd0, data_byte};
               end else begin
                  toff = off - 4'd2;
                  xf_in[toff[2:1]] = put_byte(xf_in[toff[2:1]], toff[0], data_byte);
               end
            end
            if (pos_ff >= 4'd1) begin
               if ((flags_in & F_UNIFORM) != '0) begin
                  tlen = 5'd2;
               end else if ((flags_in & F_XY) != '0) begin
                  tlen = 5'd4;
               end else if ((flags_in & F_MATRIX) != '0) begin
                  tlen = 5'd8;
               end
               total = 5'd6 + tlen + (((flags_in & F_WORDS) != '0) ? 5'd2 : 5'd0);
               if (next_pos >= total) begin
                  emit   = 1'b1;
                  pos_in = '0;
                  if ((flags_in & F_MORE) == '0) begin
                     phase_in = PHASE_IDLE;
                  end
               end else begin
                  pos_in = next_pos[3:0];
               end
            end else begin
               pos_in = 4'd1;
            end
         end
         default: begin
         end
      endcase

      if (glyph_end) begin
         counter_in = counter_ff + 16'd1;
         phase_in   = PHASE_HEADER;
         pos_in     = '0;
      end
   end

   always_comb begin
      result.glyph_number    = counter_ff;
      result.component_glyph = index_in;
      result.component_flags = flags_in;
      result.first_argument  = arg_in[0];
      result.second_argument = arg_in[1];
      result.last_component  = (flags_in & F_MORE) == '0;
      result.transform_kind  = KIND_UNIFORM;
      result.transform_a     = ONE_F2DOT14;
      result.transform_b     = '0;
      result.transform_c     = '0;
      result.transform_d     = '0;
      if ((flags_in & F_UNIFORM) != '0) begin
         result.transform_a = xf_in[0];
      end else if ((flags_in & F_XY) != '0) begin
         result.transform_kind = KIND_XY;
         result.transform_a    = xf_in[0];
         result.transform_b    = xf_in[1];
      end else if ((flags_in & F_MATRIX) != '0) begin
         result.transform_kind = KIND_MATRIX;
         result.transform_a    = xf_in[0];
         result.transform_b    = xf_in[1];
         result.transform_c    = xf_in[2];
         result.transform_d    = xf_in[3];
      end
   end

endmodule

/* src/composite_glyph_record_parser_core.sv */
// A record's result is presented from the output register in the cycle after its final byte is accepted.
// Throughput: one byte per cycle; the parser state updates in a single pass per byte.
// A held result in the output register stalls input only while rsp_tready is low.
// Reset (synchronous, active high) clears the glyph count, the parser phase and
// the output valid; the parser restarts in the header phase.
module composite_glyph_record_parser_core
   import cgrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // glyph_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] glyph_number, [31:16] component_glyph, [47:32] component_flags,
   // [63:48] first_argument, [79:64] second_argument, [81:80] transform_kind,
   // [97:82] transform_a, [113:98] transform_b, [129:114] transform_c,
   // [145:130] transform_d, [151:146] zero
   output logic [151:0] rsp_tdata,
   output logic         rsp_tlast    // last_component
);

   logic       accept;
   logic       emit;
   result_type result;

   logic         rsp_valid_ff;
   logic [151:0] rsp_data_ff;
   logic         rsp_last_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   cgrp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(accept),
      .data_byte (req_tdata),
      .glyph_end (req_tlast),
      .emit      (emit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= {6'd0,
                         result.transform_d,
                         result.transform_c,
                         result.transform_b,
                         result.transform_a,
                         result.transform_kind,
                         result.second_argument,
                         result.first_argument,
                         result.component_flags,
                         result.component_glyph,
                         result.glyph_number};
         rsp_last_ff <= result.last_component;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* tb/tb_composite_glyph_record_parser_core.sv */
`timescale 1ns / 100ps

module tb_composite_glyph_record_parser_core;
   import cgrp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_BYTES   = 440;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;
   logic         rsp_tlast;

   // parser state as predicted
   logic [15:0] glyph_count = '0;
   phase_type   phase       = PHASE_HEADER;
   logic [3:0]  position    = '0;
   logic [7:0]  count_high  = '0;
   logic [15:0] rec_flags   = '0;
   logic [15:0] rec_index   = '0;
   logic [15:0] rec_args [2];
   logic [15:0] rec_xform [4];

   result_type  pending_records [$];
   logic [7:0]  glyph_q [$];
   int          failures     = 0;
   int          random_bytes = 0;
   int          long_hold    = 0;
   bit          req_idling   = 1'b1;
   bit          rsp_idling   = 1'b1;

   composite_glyph_record_parser_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] merge_byte(logic [15:0] w, logic odd, logic [7:0] b);
      return odd ? {w[15:8], b} : {b, w[7:0]};
   endfunction

   function automatic int xform_bytes(logic [15:0] flags);
      if ((flags & F_UNIFORM) != '0) return 2;
      if ((flags & F_XY) != '0) return 4;
      if ((flags & F_MATRIX) != '0) return 8;
      return 0;
   endfunction

   function automatic int stall_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   function automatic int offer_gap();
      if (!req_idling || $urandom_range(0, 2) != 0) return 0;
      return stall_length();
   endfunction

   task automatic parse_glyph_byte(input logic [7:0] b, input logic glyph_end);
      int p;
      int alen;
      int o;
      result_type r;
      p = position;
      if (phase == PHASE_HEADER) begin
         if (p == 0) count_high = b;
         if (p + 1 >= HEADER_BYTES) begin
            phase = count_high[7] ? PHASE_RECORD : PHASE_IDLE;
            position = '0;
         end else begin
            position = 4'(p + 1);
         end
      end else if (phase == PHASE_RECORD) begin
         if (p == 0) begin
            rec_flags = '0;
            rec_index = '0;
            rec_args = '{default: '0};
            rec_xform = '{default: '0};
         end
         if (p < 2) begin
            rec_flags = merge_byte(rec_flags, p[0], b);
         end else if (p < 4) begin
            rec_index = merge_byte(rec_index, p[0], b);
         end else begin
            alen = ((rec_flags & F_WORDS) != '0) ? 4 : 2;
            o = p - 4;
            if (o < alen) begin
               if (alen == 4) rec_args[o[1]] = merge_byte(rec_args[o[1]], o[0], b);
               else rec_args[o[0]] = {8'h00, b};
            end else begin
               o = o - alen;
               rec_xform[o[2:1]] = merge_byte(rec_xform[o[2:1]], o[0], b);
            end
         end
         if (p >= 1) begin
            alen = ((rec_flags & F_WORDS) != '0) ? 4 : 2;
            if (p + 1 >= 4 + alen + xform_bytes(rec_flags)) begin
               r.glyph_number    = glyph_count;
               r.component_glyph = rec_index;
               r.component_flags = rec_flags;
               r.first_argument  = rec_args[0];
               r.second_argument = rec_args[1];
               r.transform_kind  = KIND_UNIFORM;
               r.transform_a     = ONE_F2DOT14;
               r.transform_b     = '0;
               r.transform_c     = '0;
               r.transform_d     = '0;
               if ((rec_flags & F_UNIFORM) != '0) begin
                  r.transform_a = rec_xform[0];
               end else if ((rec_flags & F_XY) != '0) begin
                  r.transform_kind = KIND_XY;
                  r.transform_a    = rec_xform[0];
                  r.transform_b    = rec_xform[1];
               end else if ((rec_flags & F_MATRIX) != '0) begin
                  r.transform_kind = KIND_MATRIX;
                  r.transform_a    = rec_xform[0];
                  r.transform_b    = rec_xform[1];
                  r.transform_c    = rec_xform[2];
                  r.transform_d    = rec_xform[3];
               end
               r.last_component = ((rec_flags & F_MORE) == '0);
               pending_records.push_back(r);
               position = '0;
               if ((rec_flags & F_MORE) == '0) phase = PHASE_IDLE;
            end else begin
               position = 4'(p + 1);
            end
         end else begin
            position = 4'd1;
         end
      end
      if (glyph_end) begin
         glyph_count = glyph_count + 16'd1;
         phase = PHASE_HEADER;
         position = '0;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%h, got 0x%h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_records.size() == 0) begin
            $error("result transaction with nothing pending, glyph_number 0x%h",
                   rsp_tdata[15:0]);
            failures++;
         end else begin
            want = pending_records.pop_front();
            check_field("glyph_number", want.glyph_number, rsp_tdata[15:0]);
            check_field("component_glyph", want.component_glyph, rsp_tdata[31:16]);
            check_field("component_flags", want.component_flags, rsp_tdata[47:32]);
            check_field("first_argument", want.first_argument, rsp_tdata[63:48]);
            check_field("second_argument", want.second_argument, rsp_tdata[79:64]);
            check_field("transform_kind", 16'(want.transform_kind), 16'(rsp_tdata[81:80]));
            check_field("transform_a", want.transform_a, rsp_tdata[97:82]);
            check_field("transform_b", want.transform_b, rsp_tdata[113:98]);
            check_field("transform_c", want.transform_c, rsp_tdata[129:114]);
            check_field("transform_d", want.transform_d, rsp_tdata[145:130]);
            check_field("last_component", 16'(want.last_component), 16'(rsp_tlast));
            check_field("tdata padding", '0, 16'(rsp_tdata[151:146]));
         end
      end
   end

   // receiver: random stalls, plus an occasional long hold-off on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold != 0) begin
            n = long_hold;
            long_hold = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_idling && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_length()) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic glyph_end);
      int gap;
      gap = offer_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= glyph_end;
      do @(posedge clock); while (req_tready !== 1'b1);
      parse_glyph_byte(b, glyph_end);
   endtask

   task automatic send_glyph();
      for (int i = 0; i < glyph_q.size(); i++) send_byte(glyph_q[i], i == glyph_q.size() - 1);
      glyph_q.delete();
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
   endtask

   task automatic trim_glyph(input int len);
      while (glyph_q.size() > len) void'(glyph_q.pop_back());
   endtask

   task automatic add_word(input logic [15:0] w);
      glyph_q.push_back(w[15:8]);
      glyph_q.push_back(w[7:0]);
   endtask

   task automatic add_random_bytes(input int n);
      repeat (n) glyph_q.push_back(8'($urandom));
   endtask

   task automatic add_header(input logic [15:0] contours);
      add_word(contours);
      add_random_bytes(8);
   endtask

   task automatic add_record(input logic [15:0] flags, input logic [15:0] gidx,
                             input logic [15:0] a0, input logic [15:0] a1,
                             input logic [15:0] t0, input logic [15:0] t1,
                             input logic [15:0] t2, input logic [15:0] t3);
      int n;
      add_word(flags);
      add_word(gidx);
      if ((flags & F_WORDS) != '0) begin
         add_word(a0);
         add_word(a1);
      end else begin
         glyph_q.push_back(a0[7:0]);
         glyph_q.push_back(a1[7:0]);
      end
      n = xform_bytes(flags);
      if (n >= 2) add_word(t0);
      if (n >= 4) add_word(t1);
      if (n == 8) begin
         add_word(t2);
         add_word(t3);
      end
   endtask

   task automatic add_random_record(input bit more);
      logic [15:0] f;
      f = 16'($urandom) & ~(F_UNIFORM | F_XY | F_MATRIX | F_MORE);
      case ($urandom_range(0, 7))
         2: f = f | F_UNIFORM;
         3: f = f | F_XY;
         4: f = f | F_MATRIX;
         5, 6, 7: f = f | (16'($urandom) & (F_UNIFORM | F_XY | F_MATRIX));
         default: f = f;
      endcase
      if (more) f = f | F_MORE;
      add_record(f, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic add_composite(input int records, input bit all_more);
      add_header({1'b1, 15'($urandom)});
      for (int i = 0; i < records; i++) add_random_record(all_more || i != records - 1);
   endtask

   task automatic test_short_glyphs();
      glyph_q.push_back(8'hFF);
      send_glyph();
      add_header(16'hFFFF);
      trim_glyph(9);
      send_glyph();
   endtask

   task automatic test_simple_glyphs();
      add_header(16'h0000);
      add_random_bytes(5);
      send_glyph();
      add_header(16'h7FFF);
      add_random_record(1'b0);
      send_glyph();
      add_header(16'h0001);
      send_glyph();
   endtask

   task automatic test_record_forms();
      add_header(16'hFFFF);
      add_record(F_MORE | F_WORDS, 16'h0000, 16'h8000, 16'h7FFF, '0, '0, '0, '0);
      add_record(F_MORE | F_UNIFORM, 16'hFFFF, 16'h00FF, 16'h0080, 16'h8000, '0, '0, '0);
      add_record(F_MORE | F_WORDS | F_XY, 16'h1234, 16'hFFFF, 16'h0000,
                 16'h7FFF, 16'h8000, '0, '0);
      add_record(F_MORE | F_MATRIX, 16'h0001, 16'h0000, 16'h00FF,
                 16'h4000, 16'hC000, 16'h7FFF, 16'h8000);
      add_record(F_MORE | F_UNIFORM | F_XY | F_MATRIX, 16'h00FF, 16'h0011, 16'h0022,
                 16'h2000, '0, '0, '0);
      add_record(F_MORE | F_XY | F_MATRIX, 16'hFF00, 16'h0033, 16'h0044,
                 16'hE000, 16'h1000, '0, '0);
      // last record ends exactly on the glyph end marker
      add_record(16'hFFDF, 16'hA5A5, 16'h8001, 16'h7FFE, 16'h0001, '0, '0, '0);
      send_glyph();
      // trailing instruction bytes after the last component
      add_header(16'h8000);
      add_record(F_MORE | F_WORDS, 16'h0002, 16'h0102, 16'h0304, '0, '0, '0, '0);
      add_record(16'h0002, 16'h0003, 16'h00AA, 16'h0055, '0, '0, '0, '0);
      add_word(F_MORE);
      add_random_bytes(6);
      send_glyph();
   endtask

   task automatic test_truncated_records();
      add_header(16'hFFFE);
      add_record(F_MORE | F_WORDS | F_MATRIX, 16'h0004, 16'h1111, 16'h2222,
                 16'h3333, 16'h4444, 16'h5555, 16'h6666);
      add_record(F_WORDS | F_MATRIX, 16'h0005, 16'h1111, 16'h2222,
                 16'h3333, 16'h4444, 16'h5555, 16'h6666);
      trim_glyph(glyph_q.size() - 3);
      send_glyph();
      add_header(16'hFFFD);
      add_word(F_MORE);
      trim_glyph(11);
      send_glyph();
      // more-components set on every record, glyph ends after a full record
      add_composite(2, 1'b1);
      send_glyph();
   endtask

   task automatic test_back_to_back();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      repeat (3) begin
         add_composite($urandom_range(2, 5), 1'b0);
         send_glyph();
      end
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   task automatic test_output_stall();
      wait_for_drain();
      long_hold = 300;
      add_header(16'hFFFF);
      repeat (20) add_record(F_MORE, 16'($urandom), 16'($urandom), 16'($urandom),
                             '0, '0, '0, '0);
      add_random_record(1'b0);
      send_glyph();
      wait_for_drain();
   endtask

   task automatic test_random_glyphs();
      int r;
      while (random_bytes < RANDOM_BYTES) begin
         req_idling = ($urandom_range(0, 4) != 0);
         rsp_idling = ($urandom_range(0, 4) != 0);
         r = $urandom_range(0, 19);
         if (r < 14) begin
            add_composite($urandom_range(1, 5), 1'b0);
            add_random_bytes($urandom_range(0, 4));
         end else if (r < 16) begin
            add_header({1'b0, 15'($urandom)});
            add_random_bytes($urandom_range(0, 16));
         end else if (r < 18) begin
            add_composite($urandom_range(1, 4), 1'($urandom_range(0, 1)));
            trim_glyph($urandom_range(11, glyph_q.size() - 1));
         end else if (r < 19) begin
            add_random_bytes($urandom_range(1, 9));
         end else begin
            add_random_bytes($urandom_range(1, 30));
         end
         random_bytes += glyph_q.size();
         send_glyph();
         if ($urandom_range(0, 9) == 0) wait_for_drain();
      end
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rec_args   = '{default: '0};
      rec_xform  = '{default: '0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_short_glyphs();
      test_simple_glyphs();
      test_record_forms();
      test_truncated_records();
      test_back_to_back();
      test_output_stall();
      test_random_glyphs();

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/cgrp_pkg.sv
src/cgrp_parser.sv
src/composite_glyph_record_parser_core.sv
tb/tb_composite_glyph_record_parser_core.sv
